// File: rtl/core/srqt_pkg.sv
// Shared types, constants and the angle decoder of the selection rotate unit.
package srqt_pkg;

	localparam int DIM_W       = 9;
	localparam int PIX_W       = 24;
	localparam int MODE_W      = 3;
	localparam int STAT_W      = 3;
	localparam int ANG_W       = 10;
	localparam int TURN_W      = 2;
	localparam int MAX_DIM_DEF = 256;
	localparam int IN_DATA_W   = 88;
	localparam int OUT_DATA_W  = 48;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE  = 3'd0,
		MODE_READ   = 3'd1,
		MODE_SIZE   = 3'd2,
		MODE_SELECT = 3'd3,
		MODE_ROTATE = 3'd4
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK         = 3'd0,
		STAT_NO_IMAGE   = 3'd1,
		STAT_NOT_SQUARE = 3'd2,
		STAT_BAD_ANGLE  = 3'd3,
		STAT_RANGE      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_OUT_COPY,
		ST_OUT_DRAIN,
		ST_BACK_COPY,
		ST_BACK_DRAIN
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [TURN_W-1:0] turns;
	} turn_dec_t;

	// Maps a requested angle to a count of 270-degree steps.
	function automatic turn_dec_t angle_turns(input logic signed [ANG_W-1:0] a);
		turn_dec_t d;
		d.valid = 1'b1;
		d.turns = 2'd0;
		case (a)
			-10'sd90, 10'sd270:            d.turns = 2'd1;
			10'sd180, -10'sd180:           d.turns = 2'd2;
			10'sd90, -10'sd270:            d.turns = 2'd3;
			10'sd0, 10'sd360, -10'sd360:   d.turns = 2'd0;
			default:                       d.valid = 1'b0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/core/selection_rotate_by_quarter_turns_unit.sv
// Top level of the selection rotate unit: frame store, scratch store and command sequencer.
//
// Channel   Dir  Handshake                      Content
// cfg       in   cfg_valid / cfg_ready          color_mode in cfg_data
// s_axis    in   s_axis_tvalid / s_axis_tready  one command item
// m_axis    out  m_axis_tvalid / m_axis_tready  one result item per command
//
// Pixel writes, size, selection and rejected commands load the result register when accepted;
// a pixel read first passes through ST_READ, as the frame memory read is registered.
// A rotation by n quarter turns of an h by w region copies the region into the scratch memory
// and back once per turn, one entry a cycle.
// Reset clears the control state only; the memories are not cleared.
// An item is taken in the idle state while the result register is empty or is being emptied in the same cycle.
module selection_rotate_by_quarter_turns_unit #(
	parameter int MAX_DIM = srqt_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data,      // color_mode
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// row, column, row_end, column_end, image_height, image_width, pixel_in, angle_deg
	input  logic [srqt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic [srqt_pkg::MODE_W-1:0]       s_axis_tuser,  // mode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_out, status, cur_height, cur_width, zero fill
	output logic [srqt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	localparam int AW    = $clog2(MAX_DIM);
	localparam int DEPTH = 1 << (2 * AW);

	logic [srqt_pkg::PIX_W-1:0] frame_mem   [0:DEPTH-1];
	logic [srqt_pkg::PIX_W-1:0] scratch_mem [0:DEPTH-1];

	srqt_pkg::state_t state_q, state_d;

	logic [srqt_pkg::DIM_W-1:0] height_q, width_q;
	logic [srqt_pkg::DIM_W-1:0] sel_top_q, sel_left_q, sel_bottom_q, sel_right_q;
	logic                       loaded_q;
	logic                       color_q;
	logic [srqt_pkg::TURN_W-1:0] turns_q;
	logic [srqt_pkg::DIM_W-1:0] i_q, j_q;

	logic                       out_valid_q;
	logic [srqt_pkg::PIX_W-1:0] out_pixel_q;
	logic [srqt_pkg::STAT_W-1:0] out_status_q;

	logic                       sc_we_s1, fr_we_s1;
	logic [2*AW-1:0]            cp_wa_s1;

	logic [srqt_pkg::PIX_W-1:0] frame_rd_q, scratch_rd_q;

	logic [srqt_pkg::DIM_W-1:0] in_row, in_col, in_row_end, in_col_end, in_height, in_width;
	logic [srqt_pkg::PIX_W-1:0] in_pixel;
	logic signed [srqt_pkg::ANG_W-1:0] in_angle;

	logic [srqt_pkg::DIM_W-1:0] sel_h, sel_w;
	logic                       cnt_last;
	srqt_pkg::turn_dec_t        ang_dec;
	logic [srqt_pkg::PIX_W-1:0] pix_mask;

	logic                        in_acc;
	logic                        load;
	logic [srqt_pkg::STAT_W-1:0] ld_status;
	logic [srqt_pkg::PIX_W-1:0]  ld_pixel;
	logic                        pix_wr, size_wr, sel_wr, rot_start;
	logic                        cnt_step, cnt_clr, turn_end;

	logic [2*AW-1:0]            pix_addr, src_addr, scr_addr, dst_addr;
	logic [srqt_pkg::DIM_W-1:0] src_row, src_col, dst_row, dst_col;
	logic                       frame_we;
	logic [2*AW-1:0]            frame_wa, frame_ra;
	logic [srqt_pkg::PIX_W-1:0] frame_wd;

	assign in_row     = s_axis_tdata[8:0];
	assign in_col     = s_axis_tdata[17:9];
	assign in_row_end = s_axis_tdata[26:18];
	assign in_col_end = s_axis_tdata[35:27];
	assign in_height  = s_axis_tdata[44:36];
	assign in_width   = s_axis_tdata[53:45];
	assign in_pixel   = s_axis_tdata[77:54];
	assign in_angle   = s_axis_tdata[87:78];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == srqt_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, width_q, height_q, out_status_q, out_pixel_q};

	assign sel_h    = sel_bottom_q - sel_top_q;
	assign sel_w    = sel_right_q - sel_left_q;
	assign cnt_last = (j_q == sel_h - 9'd1) && (i_q == sel_w - 9'd1);
	assign ang_dec  = srqt_pkg::angle_turns(in_angle);
	assign pix_mask = color_q ? 24'hFFFFFF : 24'h0000FF;

	assign src_row  = sel_top_q + j_q;
	assign src_col  = sel_left_q + (sel_w - 9'd1 - i_q);
	assign dst_row  = sel_top_q + i_q;
	assign dst_col  = sel_left_q + j_q;
	assign pix_addr = {AW'(in_row), AW'(in_col)};
	assign src_addr = {AW'(src_row), AW'(src_col)};
	assign scr_addr = {AW'(i_q), AW'(j_q)};
	assign dst_addr = {AW'(dst_row), AW'(dst_col)};

	assign frame_ra = (state_q == srqt_pkg::ST_OUT_COPY) ? src_addr : pix_addr;
	assign frame_we = fr_we_s1 || pix_wr;
	assign frame_wa = fr_we_s1 ? cp_wa_s1 : pix_addr;
	assign frame_wd = fr_we_s1 ? scratch_rd_q : (in_pixel & pix_mask);

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		ld_status = srqt_pkg::STAT_OK;
		ld_pixel  = '0;
		pix_wr    = 1'b0;
		size_wr   = 1'b0;
		sel_wr    = 1'b0;
		rot_start = 1'b0;
		cnt_step  = 1'b0;
		cnt_clr   = 1'b0;
		turn_end  = 1'b0;
		case (state_q)
			srqt_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (s_axis_tuser)
						srqt_pkg::MODE_WRITE, srqt_pkg::MODE_READ: begin
							if (!loaded_q) begin
								load      = 1'b1;
								ld_status = srqt_pkg::STAT_NO_IMAGE;
							end else if (in_row >= height_q || in_col >= width_q) begin
								load      = 1'b1;
								ld_status = srqt_pkg::STAT_RANGE;
							end else if (s_axis_tuser == srqt_pkg::MODE_WRITE) begin
								pix_wr = 1'b1;
								load   = 1'b1;
							end else begin
								state_d = srqt_pkg::ST_READ;
							end
						end
						srqt_pkg::MODE_SIZE: begin
							load = 1'b1;
							if (in_height == '0 || in_width == '0 ||
							    32'(in_height) > 32'(MAX_DIM) || 32'(in_width) > 32'(MAX_DIM)) begin
								ld_status = srqt_pkg::STAT_RANGE;
							end else begin
								size_wr = 1'b1;
							end
						end
						srqt_pkg::MODE_SELECT: begin
							load = 1'b1;
							if (!loaded_q) begin
								ld_status = srqt_pkg::STAT_NO_IMAGE;
							end else if (!(in_row < in_row_end && in_row_end <= height_q &&
							               in_col < in_col_end && in_col_end <= width_q)) begin
								ld_status = srqt_pkg::STAT_RANGE;
							end else begin
								sel_wr = 1'b1;
							end
						end
						srqt_pkg::MODE_ROTATE: begin
							if (!loaded_q) begin
								load      = 1'b1;
								ld_status = srqt_pkg::STAT_NO_IMAGE;
							end else if (sel_h != sel_w &&
							             (sel_h != height_q || sel_w != width_q)) begin
								load      = 1'b1;
								ld_status = srqt_pkg::STAT_NOT_SQUARE;
							end else if (!ang_dec.valid) begin
								load      = 1'b1;
								ld_status = srqt_pkg::STAT_BAD_ANGLE;
							end else if (ang_dec.turns == '0) begin
								load = 1'b1;
							end else begin
								rot_start = 1'b1;
								state_d   = srqt_pkg::ST_OUT_COPY;
							end
						end
						default: begin
							load      = 1'b1;
							ld_status = srqt_pkg::STAT_RANGE;
						end
					endcase
				end
			end
			srqt_pkg::ST_READ: begin
				load     = 1'b1;
				ld_pixel = frame_rd_q & pix_mask;
				state_d  = srqt_pkg::ST_IDLE;
			end
			srqt_pkg::ST_OUT_COPY: begin
				cnt_step = 1'b1;
				if (cnt_last) begin
					state_d = srqt_pkg::ST_OUT_DRAIN;
				end
			end
			srqt_pkg::ST_OUT_DRAIN: begin
				cnt_clr = 1'b1;
				state_d = srqt_pkg::ST_BACK_COPY;
			end
			srqt_pkg::ST_BACK_COPY: begin
				cnt_step = 1'b1;
				if (cnt_last) begin
					state_d = srqt_pkg::ST_BACK_DRAIN;
				end
			end
			srqt_pkg::ST_BACK_DRAIN: begin
				cnt_clr  = 1'b1;
				turn_end = 1'b1;
				if (turns_q == 2'd1) begin
					load    = 1'b1;
					state_d = srqt_pkg::ST_IDLE;
				end else begin
					state_d = srqt_pkg::ST_OUT_COPY;
				end
			end
			default: begin
				state_d = srqt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srqt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q     <= '0;
			width_q      <= '0;
			sel_top_q    <= '0;
			sel_left_q   <= '0;
			sel_bottom_q <= '0;
			sel_right_q  <= '0;
			loaded_q     <= 1'b0;
			color_q      <= 1'b0;
			turns_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			out_valid_q  <= 1'b0;
			sc_we_s1     <= 1'b0;
			fr_we_s1     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
			if (size_wr) begin
				height_q     <= in_height;
				width_q      <= in_width;
				sel_top_q    <= '0;
				sel_left_q   <= '0;
				sel_bottom_q <= in_height;
				sel_right_q  <= in_width;
				loaded_q     <= 1'b1;
			end
			if (sel_wr) begin
				sel_top_q    <= in_row;
				sel_left_q   <= in_col;
				sel_bottom_q <= in_row_end;
				sel_right_q  <= in_col_end;
			end
			if (rot_start) begin
				turns_q <= ang_dec.turns;
				i_q     <= '0;
				j_q     <= '0;
			end
			if (cnt_step) begin
				if (j_q == sel_h - 9'd1) begin
					j_q <= '0;
					i_q <= i_q + 9'd1;
				end else begin
					j_q <= j_q + 9'd1;
				end
			end
			if (cnt_clr) begin
				i_q <= '0;
				j_q <= '0;
			end
			if (turn_end) begin
				turns_q <= turns_q - 2'd1;
				if (sel_h != sel_w) begin
					height_q     <= sel_w;
					width_q      <= sel_h;
					sel_bottom_q <= sel_top_q + sel_w;
					sel_right_q  <= sel_left_q + sel_h;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			sc_we_s1 <= (state_q == srqt_pkg::ST_OUT_COPY);
			fr_we_s1 <= (state_q == srqt_pkg::ST_BACK_COPY);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pixel_q  <= ld_pixel;
			out_status_q <= ld_status;
		end
		cp_wa_s1 <= (state_q == srqt_pkg::ST_OUT_COPY) ? scr_addr : dst_addr;
	end

	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[frame_wa] <= frame_wd;
		end
		frame_rd_q <= frame_mem[frame_ra];
	end

	always_ff @(posedge clk) begin
		if (sc_we_s1) begin
			scratch_mem[cp_wa_s1] <= frame_rd_q;
		end
		scratch_rd_q <= scratch_mem[scr_addr];
	end

endmodule

// File: sim/selection_rotate_by_quarter_turns_unit_tb.sv
// Self-checking testbench: directed and random command streams against a frame store and rotation predictor.
`timescale 1ns / 100ps

module selection_rotate_by_quarter_turns_unit_tb;

	localparam int SIDE = srqt_pkg::MAX_DIM_DEF;
	localparam int PHASE_ITEMS = 250;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [srqt_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [srqt_pkg::MODE_W-1:0] MODE_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [srqt_pkg::MODE_W-1:0] mode;
		logic [srqt_pkg::ANG_W-1:0]  angle;
		logic [srqt_pkg::PIX_W-1:0]  pixel;
		logic [srqt_pkg::DIM_W-1:0]  img_w;
		logic [srqt_pkg::DIM_W-1:0]  img_h;
		logic [srqt_pkg::DIM_W-1:0]  col_end;
		logic [srqt_pkg::DIM_W-1:0]  row_end;
		logic [srqt_pkg::DIM_W-1:0]  col;
		logic [srqt_pkg::DIM_W-1:0]  row;
	} command_t;

	typedef struct packed {
		logic [2:0]                 fill;
		logic [srqt_pkg::DIM_W-1:0] width;
		logic [srqt_pkg::DIM_W-1:0] height;
		srqt_pkg::status_t          status;
		logic [srqt_pkg::PIX_W-1:0] pixel;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [srqt_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [srqt_pkg::MODE_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [srqt_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	selection_rotate_by_quarter_turns_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Predicted state of the block.
	logic [srqt_pkg::PIX_W-1:0] pixel_mem [0:SIDE*SIDE-1];
	bit pixel_written [0:SIDE*SIDE-1];
	logic [srqt_pkg::PIX_W-1:0] scratch_pix [0:SIDE*SIDE-1];
	bit scratch_written [0:SIDE*SIDE-1];
	logic [srqt_pkg::DIM_W-1:0] frame_h = '0, frame_w = '0;
	logic [srqt_pkg::DIM_W-1:0] sel_top = '0, sel_left = '0, sel_bottom = '0, sel_right = '0;
	bit image_loaded = 1'b0;
	bit color_mode = 1'b0;

	command_t command_queue[$];
	reply_t reply_queue[$];
	command_t cur_cmd;
	bit cmd_busy = 1'b0;
	int items_queued = 0;
	int mismatch_count = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int turn_angles[9] = '{-90, 270, 180, -180, 90, -270, 0, 360, -360};

	always #5 clk = ~clk;

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#200000000;
		$display("selection_rotate_by_quarter_turns_unit test failed");
		$finish;
	end

	// One 270-degree step of the current selection, through the scratch store.
	function automatic void turn_region();
		int h, w, i, j;
		h = sel_bottom - sel_top;
		w = sel_right - sel_left;
		for (i = 0; i < w; i++)
			for (j = 0; j < h; j++) begin
				scratch_pix[i*SIDE+j] = pixel_mem[(sel_top+j)*SIDE + sel_left + w - 1 - i];
				scratch_written[i*SIDE+j] = pixel_written[(sel_top+j)*SIDE + sel_left + w - 1 - i];
			end
		for (i = 0; i < w; i++)
			for (j = 0; j < h; j++) begin
				pixel_mem[(sel_top+i)*SIDE + sel_left + j] = scratch_pix[i*SIDE+j];
				pixel_written[(sel_top+i)*SIDE + sel_left + j] = scratch_written[i*SIDE+j];
			end
		if (h != w) begin
			frame_h = 9'(w);
			frame_w = 9'(h);
			sel_bottom = sel_top + 9'(w);
			sel_right = sel_left + 9'(h);
		end
	endfunction

	function automatic reply_t execute_command(command_t c);
		reply_t r;
		logic [srqt_pkg::PIX_W-1:0] keep;
		logic [srqt_pkg::DIM_W-1:0] sh, sw;
		logic [15:0] at;
		int a, turns;
		r = '0;
		keep = color_mode ? 24'hFFFFFF : 24'h0000FF;
		at = {c.row[7:0], c.col[7:0]};
		case (c.mode)
			srqt_pkg::MODE_WRITE, srqt_pkg::MODE_READ: begin
				if (!image_loaded)
					r.status = srqt_pkg::STAT_NO_IMAGE;
				else if (c.row >= frame_h || c.col >= frame_w)
					r.status = srqt_pkg::STAT_RANGE;
				else if (c.mode == srqt_pkg::MODE_WRITE) begin
					pixel_mem[at] = c.pixel & keep;
					pixel_written[at] = 1'b1;
				end else
					r.pixel = pixel_mem[at] & keep;
			end
			srqt_pkg::MODE_SIZE: begin
				if (c.img_h == 0 || c.img_w == 0 || c.img_h > SIDE || c.img_w > SIDE)
					r.status = srqt_pkg::STAT_RANGE;
				else begin
					frame_h = c.img_h;
					frame_w = c.img_w;
					sel_top = '0;
					sel_left = '0;
					sel_bottom = c.img_h;
					sel_right = c.img_w;
					image_loaded = 1'b1;
				end
			end
			srqt_pkg::MODE_SELECT: begin
				if (!image_loaded)
					r.status = srqt_pkg::STAT_NO_IMAGE;
				else if (!(c.row < c.row_end && c.row_end <= frame_h &&
						c.col < c.col_end && c.col_end <= frame_w))
					r.status = srqt_pkg::STAT_RANGE;
				else begin
					sel_top = c.row;
					sel_left = c.col;
					sel_bottom = c.row_end;
					sel_right = c.col_end;
				end
			end
			srqt_pkg::MODE_ROTATE: begin
				sh = sel_bottom - sel_top;
				sw = sel_right - sel_left;
				a = $signed(c.angle);
				case (a)
					-90, 270: turns = 1;
					180, -180: turns = 2;
					90, -270: turns = 3;
					0, 360, -360: turns = 0;
					default: turns = -1;
				endcase
				if (!image_loaded)
					r.status = srqt_pkg::STAT_NO_IMAGE;
				else if (sh != sw && (sh != frame_h || sw != frame_w))
					r.status = srqt_pkg::STAT_NOT_SQUARE;
				else if (turns < 0)
					r.status = srqt_pkg::STAT_BAD_ANGLE;
				else
					repeat (turns) turn_region();
			end
			default: r.status = srqt_pkg::STAT_RANGE;
		endcase
		r.height = frame_h;
		r.width = frame_w;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Monitor: checks results, then records configuration writes and accepted commands.
	always @(posedge clk) begin : monitor
		reply_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = reply_t'(m_axis_tdata);
				if (reply_queue.size() == 0) begin
					$error("result item arrived with no command outstanding");
					mismatch_count++;
				end else begin
					want = reply_queue.pop_front();
					check_field("pixel_out", 32'(want.pixel), 32'(got.pixel));
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("cur_height", 32'(want.height), 32'(got.height));
					check_field("cur_width", 32'(want.width), 32'(got.width));
				end
			end
			if (cfg_valid && cfg_ready)
				color_mode = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				reply_queue.push_back(execute_command(cur_cmd));
				cmd_busy = 1'b0;
			end
		end
	end

	// Driver: presents queued commands and randomizes result back-pressure.
	always @(negedge clk) begin : driver
		if (!cmd_busy) begin
			if (command_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				cur_cmd = command_queue.pop_front();
				cmd_busy = 1'b1;
				s_axis_tdata <= cur_cmd[srqt_pkg::IN_DATA_W-1:0];
				s_axis_tuser <= cur_cmd.mode;
				s_axis_tvalid <= 1'b1;
			end else
				s_axis_tvalid <= 1'b0;
		end
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic command_t random_cmd(logic [srqt_pkg::MODE_W-1:0] m);
		logic [95:0] raw;
		command_t c;
		raw = {$urandom(), $urandom(), $urandom()};
		c = command_t'(raw[$bits(command_t)-1:0]);
		c.mode = m;
		return c;
	endfunction

	function automatic command_t pixel_cmd(logic [srqt_pkg::MODE_W-1:0] m, int r, int c,
			logic [srqt_pkg::PIX_W-1:0] v);
		command_t x;
		x = random_cmd(m);
		x.row = 9'(r);
		x.col = 9'(c);
		x.pixel = v;
		return x;
	endfunction

	function automatic command_t size_cmd(int h, int w);
		command_t x;
		x = random_cmd(srqt_pkg::MODE_SIZE);
		x.img_h = 9'(h);
		x.img_w = 9'(w);
		return x;
	endfunction

	function automatic command_t select_cmd(int top, int left, int bottom, int right);
		command_t x;
		x = random_cmd(srqt_pkg::MODE_SELECT);
		x.row = 9'(top);
		x.col = 9'(left);
		x.row_end = 9'(bottom);
		x.col_end = 9'(right);
		return x;
	endfunction

	function automatic command_t rotate_cmd(int a);
		command_t x;
		x = random_cmd(srqt_pkg::MODE_ROTATE);
		x.angle = 10'(a);
		return x;
	endfunction

	function automatic void push(command_t c);
		command_queue.push_back(c);
		items_queued++;
	endfunction

	task automatic wait_idle();
		while (command_queue.size() != 0 || cmd_busy) begin
			@(posedge clk);
			#1;
		end
	endtask

	task automatic wait_drained();
		while (command_queue.size() != 0 || cmd_busy || reply_queue.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_color(bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A burst starts from a settled prediction: optional new size, pixel traffic with reads
	// only of written pixels, some malformed commands, and usually a selection plus rotate.
	task automatic plan_burst();
		int h, w, p, n, rr, cc, s, top, left;
		bit planned [int];
		wait_idle();
		h = frame_h;
		w = frame_w;
		if (!image_loaded || $urandom_range(0, 99) < 20) begin
			if ($urandom_range(0, 99) < 15)
				push(size_cmd($urandom_range(0, 1) ? 0 : $urandom_range(257, 511),
					$urandom_range(0, 511)));
			p = $urandom_range(0, 99);
			if (p < 2) begin
				h = SIDE;
				w = SIDE;
			end else if (p < 6) begin
				h = $urandom_range(0, 1) ? SIDE : SIDE - 1;
				w = $urandom_range(1, 4);
				if ($urandom_range(0, 1)) begin
					s = h;
					h = w;
					w = s;
				end
			end else if (p < 25) begin
				h = $urandom_range(1, 16);
				w = $urandom_range(1, 16);
			end else begin
				h = $urandom_range(1, 6);
				w = $urandom_range(1, 6);
			end
			push(size_cmd(h, w));
		end
		n = $urandom_range(1, 6);
		repeat (n) begin
			p = $urandom_range(0, 99);
			rr = $urandom_range(0, h - 1);
			cc = $urandom_range(0, w - 1);
			if (p < 35) begin
				push(pixel_cmd(srqt_pkg::MODE_WRITE, rr, cc, 24'($urandom())));
				planned[rr*SIDE+cc] = 1'b1;
			end else if (p < 70) begin
				if (!pixel_written[rr*SIDE+cc] && !planned.exists(rr*SIDE+cc)) begin
					push(pixel_cmd(srqt_pkg::MODE_WRITE, rr, cc, 24'($urandom())));
					planned[rr*SIDE+cc] = 1'b1;
				end
				push(pixel_cmd(srqt_pkg::MODE_READ, rr, cc, 24'($urandom())));
			end else if (p < 78) begin
				if ($urandom_range(0, 1))
					push(pixel_cmd($urandom_range(0, 1) ? srqt_pkg::MODE_WRITE :
						srqt_pkg::MODE_READ, $urandom_range(h, 511),
						$urandom_range(0, 511), 24'($urandom())));
				else
					push(pixel_cmd($urandom_range(0, 1) ? srqt_pkg::MODE_WRITE :
						srqt_pkg::MODE_READ, $urandom_range(0, 511),
						$urandom_range(w, 511), 24'($urandom())));
			end else if (p < 88)
				push(random_cmd(srqt_pkg::MODE_SELECT));
			else if (p < 93)
				push(size_cmd($urandom_range(0, 511), $urandom_range(0, 1) ? 0 :
					$urandom_range(257, 511)));
			else
				push(random_cmd(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST))));
		end
		if ($urandom_range(0, 99) < 80) begin
			p = $urandom_range(0, 99);
			if (p < 15 && w >= 2 && !(h == 1 && w == 2))
				push(select_cmd(0, 0, 1, 2));
			else if (p < 15 && h >= 2 && !(h == 2 && w == 1))
				push(select_cmd(0, 0, 2, 1));
			else if (p < 45 && h * w <= 1024)
				push(select_cmd(0, 0, h, w));
			else begin
				s = (h < w) ? h : w;
				if (s > 16)
					s = 16;
				s = $urandom_range(1, s);
				top = $urandom_range(0, h - s);
				left = $urandom_range(0, w - s);
				push(select_cmd(top, left, top + s, left + s));
			end
			if ($urandom_range(0, 99) < 80)
				push(rotate_cmd(turn_angles[$urandom_range(0, 8)]));
			else
				push(rotate_cmd($urandom_range(0, 1023)));
		end
	endtask

	task automatic push_directed();
		push(pixel_cmd(srqt_pkg::MODE_WRITE, 0, 0, 24'hABCDEF));
		push(pixel_cmd(srqt_pkg::MODE_READ, 0, 0, 24'h0));
		push(select_cmd(0, 0, 1, 1));
		push(rotate_cmd(90));
		push(random_cmd(MODE_SPARE_FIRST));
		push(random_cmd(MODE_SPARE_LAST));
		push(size_cmd(0, 5));
		push(size_cmd(SIDE + 1, 4));
		push(size_cmd(SIDE, 2));
		push(pixel_cmd(srqt_pkg::MODE_WRITE, SIDE - 1, 1, 24'hFFFFFF));
		push(pixel_cmd(srqt_pkg::MODE_WRITE, 0, 0, 24'h000000));
		push(pixel_cmd(srqt_pkg::MODE_WRITE, SIDE, 0, 24'h123456));
		push(pixel_cmd(srqt_pkg::MODE_WRITE, 0, 2, 24'h654321));
		// A full non-square frame turns and swaps its dimensions.
		push(rotate_cmd(-90));
		push(pixel_cmd(srqt_pkg::MODE_READ, 0, SIDE - 1, 24'h0));
		push(pixel_cmd(srqt_pkg::MODE_READ, 1, 0, 24'h0));
		push(pixel_cmd(srqt_pkg::MODE_READ, 2, 0, 24'h0));
		push(select_cmd(0, 0, 3, 3));
		push(select_cmd(1, 0, 1, 2));
		push(select_cmd(0, 0, 2, 2));
		push(rotate_cmd(45));
		push(rotate_cmd(-360));
		// The square check takes precedence over the angle check.
		push(select_cmd(0, 0, 2, 3));
		push(rotate_cmd(45));
	endtask

	initial begin : stimulus
		int phase, goal;
		@(posedge arst_n);
		@(posedge clk);
		for (phase = 0; phase < 4; phase++) begin
			write_color(phase % 2 == 0);
			case (phase)
				0: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_gap_pct = 61;
					stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct = 61;
				end
				default: begin
					send_gap_pct = 29;
					stall_pct = 29;
				end
			endcase
			if (phase == 0)
				push_directed();
			goal = items_queued + PHASE_ITEMS;
			while (items_queued < goal)
				plan_burst();
			wait_drained();
		end
		if (mismatch_count == 0)
			$display("selection_rotate_by_quarter_turns_unit test passed");
		else
			$display("selection_rotate_by_quarter_turns_unit test failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/srqt_pkg.sv
rtl/core/selection_rotate_by_quarter_turns_unit.sv
sim/selection_rotate_by_quarter_turns_unit_tb.sv
